// ===== hw/rtl/ring_buffer_fifo_overwrite_unit_defines.svh =====
// Assertion macros for the ring buffer FIFO checker.
// No dependencies; included by the checker file.
`ifndef RING_BUFFER_FIFO_OVERWRITE_UNIT_DEFINES_SVH
`define RING_BUFFER_FIFO_OVERWRITE_UNIT_DEFINES_SVH

// Check a property outside reset.
`define RBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rbf_pkg.sv =====
// Package for the ring buffer FIFO: defaults, widths, op codes, stage record.
// No dependencies.
package rbf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int SLOTS_DEF      = 256;
    localparam int DEPTH_W        = 8;
    localparam int OP_W           = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_OVR = 3'd0,
        OP_PUSH_LIM = 3'd1,
        OP_POP      = 3'd2,
        OP_PEEK_OLD = 3'd3,
        OP_PEEK_NEW = 3'd4,
        OP_PEEK_OFF = 3'd5
    } t_op;

    typedef struct packed {
        logic               status;
        logic               rd_use;
        logic               dropped;
        logic [DEPTH_W-1:0] occ;
    } t_meta;

endpackage

// ===== hw/rtl/ring_buffer_fifo_overwrite_unit.sv =====
// Ring buffer FIFO with one empty slot: overwrite/limited push, pop and peeks.
// Depends on rbf_pkg.
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid / o_in_stall  op, push_data, peek_offset
//   out       output     o_out_valid / i_out_stall status, read_data, occupancy,
//                                                 dropped_oldest
//   cfg       input      i_cfg_valid / o_cfg_ready usable_depth
//
// One transaction per cycle while the input is not stalled.
// Indices update and the slot memory is read at the accept edge; the registered
// read word and status pass through one hold stage and the output register.
// The input stalls only when the hold stage and the output register are full and the output is stalled.
// Reset is synchronous; the slot memory is not cleared, indices go to zero.
module ring_buffer_fifo_overwrite_unit #(
    parameter int DATA_WIDTH = rbf_pkg::DATA_WIDTH_DEF,
    parameter int SLOTS      = rbf_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rbf_pkg::OP_W-1:0]     i_in_op,
    input  logic [DATA_WIDTH-1:0]        i_in_push_data,
    input  logic [rbf_pkg::DEPTH_W-1:0]  i_in_peek_offset,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_out_status,
    output logic [DATA_WIDTH-1:0]        o_out_read_data,
    output logic [rbf_pkg::DEPTH_W-1:0]  o_out_occupancy,
    output logic                         o_out_dropped_oldest,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rbf_pkg::DEPTH_W-1:0]  i_cfg_usable_depth
);
    import rbf_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int XW = IW + 1;
    localparam int SW = ((IW > DEPTH_W) ? IW : DEPTH_W) + 1;
    localparam int DEPTH_MAX = (1 << DEPTH_W) - 1;
    localparam int MAX_DEPTH = ((SLOTS - 1) < DEPTH_MAX) ? (SLOTS - 1) : DEPTH_MAX;

    logic [DATA_WIDTH-1:0] r_mem [SLOTS];
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic [DEPTH_W-1:0]    r_depth;
    logic [IW-1:0]         r_wi, r_ri, n_wi, n_ri;
    logic                  r_s1_valid, r_out_valid;
    t_meta                 r_s1, n_s1, r_out;
    logic [DATA_WIDTH-1:0] r_out_data;

    logic [DEPTH_W-1:0] depth, cnt;
    logic [XW-1:0]      slots, wi_x, ri_x, wi_inc, ri_inc, cnt_x;
    logic [IW-1:0]      wi_adv, ri_adv, newest, off_addr, rd_addr;
    logic [SW-1:0]      off_sum, slots_s;
    logic               we, accept, s1_adv, cfg_wr;

    always_comb begin
        if (r_depth == '0) begin
            depth = DEPTH_W'(1);
        end else if (int'(r_depth) > MAX_DEPTH) begin
            depth = DEPTH_W'(MAX_DEPTH);
        end else begin
            depth = r_depth;
        end
    end

    assign slots    = XW'(depth) + XW'(1);
    assign wi_x     = XW'(r_wi);
    assign ri_x     = XW'(r_ri);
    assign wi_inc   = wi_x + XW'(1);
    assign ri_inc   = ri_x + XW'(1);
    assign wi_adv   = (wi_inc == slots) ? '0 : IW'(wi_inc);
    assign ri_adv   = (ri_inc == slots) ? '0 : IW'(ri_inc);
    assign cnt_x    = (wi_x >= ri_x) ? (wi_x - ri_x) : (wi_x + slots - ri_x);
    assign cnt      = DEPTH_W'(cnt_x);
    assign newest   = (r_wi == '0) ? IW'(depth) : (r_wi - IW'(1));
    assign off_sum  = SW'(r_ri) + SW'(i_in_peek_offset);
    assign slots_s  = SW'(slots);
    assign off_addr = (off_sum >= slots_s) ? IW'(off_sum - slots_s) : IW'(off_sum);

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_wi    = r_wi;
        n_ri    = r_ri;
        rd_addr = r_ri;
        we      = 1'b0;
        n_s1    = '{status: 1'b0, rd_use: 1'b0, dropped: 1'b0, occ: cnt};
        unique case (t_op'(i_in_op))
            OP_PUSH_OVR: begin
                we   = 1'b1;
                n_wi = wi_adv;
                if (wi_adv == r_ri) begin
                    n_ri         = ri_adv;
                    n_s1.dropped = 1'b1;
                end else begin
                    n_s1.occ = cnt + DEPTH_W'(1);
                end
            end
            OP_PUSH_LIM: begin
                if (cnt >= depth) begin
                    n_s1.status = 1'b1;
                end else begin
                    we       = 1'b1;
                    n_wi     = wi_adv;
                    n_s1.occ = cnt + DEPTH_W'(1);
                end
            end
            OP_POP: begin
                if (cnt == '0) begin
                    n_s1.status = 1'b1;
                end else begin
                    n_s1.rd_use = 1'b1;
                    n_ri        = ri_adv;
                    n_s1.occ    = cnt - DEPTH_W'(1);
                end
            end
            OP_PEEK_OLD: begin
                if (cnt == '0) n_s1.status = 1'b1;
                else n_s1.rd_use = 1'b1;
            end
            OP_PEEK_NEW: begin
                rd_addr = newest;
                if (cnt == '0) n_s1.status = 1'b1;
                else n_s1.rd_use = 1'b1;
            end
            OP_PEEK_OFF: begin
                rd_addr = off_addr;
                if (i_in_peek_offset >= cnt) n_s1.status = 1'b1;
                else n_s1.rd_use = 1'b1;
            end
            default: begin
                n_s1.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && we) begin
            r_mem[r_wi] <= i_in_push_data;
        end
        if (accept && n_s1.rd_use) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_RST;
            r_wi        <= '0;
            r_ri        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_depth <= i_cfg_usable_depth;
                r_wi    <= '0;
                r_ri    <= '0;
            end else if (accept) begin
                r_wi <= n_wi;
                r_ri <= n_ri;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.rd_use ? r_mem_q : '0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_status         = r_out.status;
    assign o_out_read_data      = r_out_data;
    assign o_out_occupancy      = r_out.occ;
    assign o_out_dropped_oldest = r_out.dropped;

endmodule

// ===== hw/rtl/rbf_checker.sv =====
// Port-level checker for the ring buffer FIFO, bound to the top level.
// Depends on rbf_pkg and ring_buffer_fifo_overwrite_unit_defines.svh.
`include "ring_buffer_fifo_overwrite_unit_defines.svh"

module rbf_checker #(
    parameter int DATA_WIDTH = rbf_pkg::DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_out_status,
    input logic [DATA_WIDTH-1:0]        o_out_read_data,
    input logic [rbf_pkg::DEPTH_W-1:0]  o_out_occupancy,
    input logic                         o_out_dropped_oldest
);
    import rbf_pkg::*;

    `RBF_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `RBF_ASSERT(a_stall_needs_out, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stalled with free output")
    `RBF_ASSERT(a_hold_out, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_read_data) && $stable(o_out_occupancy), "stalled result changed")
    `RBF_ASSERT(a_fail_no_data, i_clk, i_rst_n, o_out_valid && o_out_status |-> o_out_read_data == '0 && !o_out_dropped_oldest, "failed transaction carries data")

endmodule

bind ring_buffer_fifo_overwrite_unit rbf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rbf_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for ring_buffer_fifo_overwrite_unit: a directed table, then random
// operations under random idling, each result checked against its table entry or against
// an in-bench queue predictor. Depends on rbf_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
    import rbf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;
    localparam int N_ROWS = 28;
    localparam int N_PHASES = 6;

    typedef struct packed {
        logic               status;
        logic [31:0]        read_data;
        logic [DEPTH_W-1:0] occupancy;
        logic               dropped;
    } t_result;

    typedef struct packed {
        bit                 is_cfg;
        logic [DEPTH_W-1:0] depth;
        logic [OP_W-1:0]    op;
        logic [31:0]        data;
        logic [DEPTH_W-1:0] off;
        bit                 typed;
        t_result            want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_in_op = '0;
    logic [31:0]        i_in_push_data = '0;
    logic [DEPTH_W-1:0] i_in_peek_offset = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_out_status;
    logic [31:0]        o_out_read_data;
    logic [DEPTH_W-1:0] o_out_occupancy;
    logic               o_out_dropped_oldest;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [DEPTH_W-1:0] i_cfg_usable_depth = '0;

    bit                 calm = 1'b0;
    int                 n_errors = 0;
    t_result            expected_q[$];

    logic [31:0]        slot_mem [256];
    logic [DEPTH_W-1:0] depth_reg = DEPTH_RST;
    int                 wr_idx = 0;
    int                 rd_idx = 0;

    ring_buffer_fifo_overwrite_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_in_op              (i_in_op),
        .i_in_push_data       (i_in_push_data),
        .i_in_peek_offset     (i_in_peek_offset),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_status         (o_out_status),
        .o_out_read_data      (o_out_read_data),
        .o_out_occupancy      (o_out_occupancy),
        .o_out_dropped_oldest (o_out_dropped_oldest),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_usable_depth   (i_cfg_usable_depth)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int eff_depth();
        return (depth_reg == 0) ? 1 : int'(depth_reg);
    endfunction

    function automatic int fill_level();
        int slots;
        slots = eff_depth() + 1;
        return (wr_idx + slots - rd_idx) % slots;
    endfunction

    function automatic t_result predict_queue_op(logic [OP_W-1:0] op, logic [31:0] data,
                                                 logic [DEPTH_W-1:0] off);
        t_result res;
        int depth, slots, cnt;
        depth = eff_depth();
        slots = depth + 1;
        cnt = fill_level();
        res = '0;
        case (op)
            OP_PUSH_OVR: begin
                slot_mem[wr_idx] = data;
                wr_idx = (wr_idx + 1) % slots;
                if (wr_idx == rd_idx) begin
                    rd_idx = (rd_idx + 1) % slots;
                    res.dropped = 1'b1;
                end
            end
            OP_PUSH_LIM: begin
                if (cnt >= depth) begin
                    res.status = 1'b1;
                end else begin
                    slot_mem[wr_idx] = data;
                    wr_idx = (wr_idx + 1) % slots;
                end
            end
            OP_POP: begin
                if (cnt == 0) begin
                    res.status = 1'b1;
                end else begin
                    res.read_data = slot_mem[rd_idx];
                    rd_idx = (rd_idx + 1) % slots;
                end
            end
            OP_PEEK_OLD: begin
                if (cnt == 0) res.status = 1'b1;
                else res.read_data = slot_mem[rd_idx];
            end
            OP_PEEK_NEW: begin
                if (cnt == 0) res.status = 1'b1;
                else res.read_data = slot_mem[(wr_idx == 0) ? depth : wr_idx - 1];
            end
            OP_PEEK_OFF: begin
                if (int'(off) >= cnt) res.status = 1'b1;
                else res.read_data = slot_mem[(rd_idx + int'(off)) % slots];
            end
            default: res.status = 1'b1;
        endcase
        res.occupancy = DEPTH_W'(fill_level());
        return res;
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [31:0] data,
                           input logic [DEPTH_W-1:0] off, input bit typed, input t_result want);
        t_result pred;
        while (!calm && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_op <= op;
        i_in_push_data <= data;
        i_in_peek_offset <= off;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_queue_op(op, data, off);
        expected_q.push_back(typed ? want : pred);
    endtask

    task automatic write_depth(input logic [DEPTH_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_usable_depth <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        depth_reg = value;
        wr_idx = 0;
        rd_idx = 0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 17);
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_status, o_out_read_data, o_out_occupancy, o_out_dropped_oldest};
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected transaction: status=%0d data=%h occ=%0d drop=%0d",
                             got.status, got.read_data, got.occupancy, got.dropped);
            end else begin
                want = expected_q.pop_front();
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch st/data/occ/drop: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                 want.status, want.read_data, want.occupancy, want.dropped,
                                 got.status, got.read_data, got.occupancy, got.dropped);
                end
            end
        end
    end

    t_row dir_rows [N_ROWS] = '{
        '{1'b0, 8'd0, OP_POP,      32'h0,         8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OLD, 32'h0,         8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_NEW, 32'h0,         8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OFF, 32'h0,         8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_UNDEF_6,  32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_UNDEF_7,  32'h0,         8'd0,   1'b1, '{1'b1, 32'h0, 8'd0, 1'b0}},
        '{1'b0, 8'd0, OP_PUSH_LIM, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b0, 32'h0, 8'd1, 1'b0}},
        '{1'b0, 8'd0, OP_PUSH_OVR, 32'h0,         8'd0,   1'b1, '{1'b0, 32'h0, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OLD, 32'h0,         8'd0,   1'b1,
          '{1'b0, 32'hFFFF_FFFF, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_NEW, 32'h0,         8'd0,   1'b1, '{1'b0, 32'h0, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OFF, 32'h0,         8'd1,   1'b1, '{1'b0, 32'h0, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OFF, 32'h0,         8'd2,   1'b1, '{1'b1, 32'h0, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_PEEK_OFF, 32'h0,         8'd255, 1'b1, '{1'b1, 32'h0, 8'd2, 1'b0}},
        '{1'b0, 8'd0, OP_POP,      32'h0,         8'd0,   1'b1,
          '{1'b0, 32'hFFFF_FFFF, 8'd1, 1'b0}},
        '{1'b1, 8'd0, OP_POP,      32'h0,         8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_PUSH_LIM, 32'hA5A5_A5A5, 8'd0,   1'b1, '{1'b0, 32'h0, 8'd1, 1'b0}},
        '{1'b0, 8'd0, OP_PUSH_LIM, 32'h1234_5678, 8'd0,   1'b1, '{1'b1, 32'h0, 8'd1, 1'b0}},
        '{1'b0, 8'd0, OP_PUSH_OVR, 32'h5A5A_5A5A, 8'd0,   1'b1, '{1'b0, 32'h0, 8'd1, 1'b1}},
        '{1'b0, 8'd0, OP_PEEK_NEW, 32'h0,         8'd0,   1'b1,
          '{1'b0, 32'h5A5A_5A5A, 8'd1, 1'b0}},
        '{1'b0, 8'd0, OP_POP,      32'h0,         8'd0,   1'b1,
          '{1'b0, 32'h5A5A_5A5A, 8'd0, 1'b0}},
        '{1'b1, 8'd2, OP_POP,      32'h0,         8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_PUSH_OVR, 32'h1111_1111, 8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_PUSH_OVR, 32'h2222_2222, 8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_PUSH_OVR, 32'h3333_3333, 8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_PEEK_OFF, 32'h0,         8'd1,   1'b0, '0},
        '{1'b0, 8'd0, OP_PEEK_NEW, 32'h0,         8'd0,   1'b0, '0},
        '{1'b0, 8'd0, OP_POP,      32'h0,         8'd0,   1'b0, '0},
        '{1'b1, 8'd255, OP_POP,    32'h0,         8'd0,   1'b0, '0}
    };

    int phase_depth [N_PHASES] = '{3, 1, 17, 0, -1, 255};
    int phase_items [N_PHASES] = '{60, 40, 80, 30, 40, 300};
    int phase_push  [N_PHASES] = '{55, 50, 60, 50, 55, 93};

    initial begin
        int pick, cnt;
        logic [OP_W-1:0] op;
        logic [DEPTH_W-1:0] off;
        for (int i = 0; i < 256; i++) slot_mem[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].is_cfg) write_depth(dir_rows[r].depth);
            else send_op(dir_rows[r].op, dir_rows[r].data, dir_rows[r].off,
                         dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_depth((phase_depth[p] < 0) ? DEPTH_W'($urandom_range(255))
                                             : DEPTH_W'(phase_depth[p]));
            calm <= (phase_depth[p] == 17);
            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(99);
                if (pick < 2)
                    op = $urandom_range(1) ? OP_UNDEF_6 : OP_UNDEF_7;
                else if (pick < 2 + phase_push[p])
                    op = $urandom_range(1) ? OP_PUSH_LIM : OP_PUSH_OVR;
                else begin
                    case ($urandom_range(3))
                        0: op = OP_POP;
                        1: op = OP_PEEK_OLD;
                        2: op = OP_PEEK_NEW;
                        default: op = OP_PEEK_OFF;
                    endcase
                end
                cnt = fill_level();
                off = ($urandom_range(4) == 0) ? DEPTH_W'($urandom_range(255))
                                               : DEPTH_W'($urandom_range(cnt));
                send_op(op, $urandom(), off, 1'b0, '0);
            end
            calm <= 1'b0;
        end

        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
